@@ rtl/core/mptp_pkg.sv @@
// package for the multi-pattern text patcher
// window geometry, pattern constants, and the structs shared by the cell chain and scanner
package mptp_pkg;

  localparam int WIN_DEPTH = 16;
  // bytes at the window front that a pattern or its digit can touch
  localparam int SCAN_SPAN = 13;
  localparam int COUNT_W   = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

  localparam int DIGIT_W = 6;
  localparam logic [DIGIT_W-1:0] DIGIT_RESET = 6'd56;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  // register index, taken from paddr[2]
  localparam logic REG_IDX_DIGIT = 1'b0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam int HYP_LEN   = 11;
  localparam int CORES_LEN = 12;
  localparam int SIB_LEN   = 11;
  localparam int HEX_LEN   = 10;

  localparam logic [7:0] PAT_HYP [HYP_LEN] =
    '{"h", "y", "p", "e", "r", "v", "i", "s", "o", "r", " "};
  localparam logic [7:0] PAT_CORES [CORES_LEN] =
    '{"c", "p", "u", " ", "c", "o", "r", "e", "s", CH_TAB, ":", " "};
  localparam logic [7:0] PAT_SIB [SIB_LEN] =
    '{"s", "i", "b", "l", "i", "n", "g", "s", CH_TAB, ":", " "};
  localparam logic [7:0] PAT_HEX [HEX_LEN] =
    '{"0", "x", "f", "f", "f", "f", "f", "f", "f", "f"};
  localparam logic [7:0] NEW_HEX [HEX_LEN] =
    '{"0", "x", "0", "0", "0", "0", "0", "0", "b", "4"};

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic                          hit;
    logic [SCAN_SPAN-1:0]          wr_en;
    logic [SCAN_SPAN-1:0][7:0]     wr_data;
  } scan_edit_t;

  function automatic logic is_digit(input logic [7:0] ch);
    return ch inside {[CH_ZERO:CH_NINE]};
  endfunction

endpackage

@@ rtl/core/mptp_cell.sv @@
// one byte cell of the delay window: holds a byte and its valid bit
// depends on mptp_pkg; takes a new byte when it is the first free cell, hands its byte left on shift
module mptp_cell
  import mptp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] din,
  input  logic       left_valid,
  input  logic       edit_en,
  input  logic [7:0] edit_data,
  input  logic [7:0] right_data,
  input  logic       right_valid,
  output logic [7:0] data_q,
  output logic       valid_q,
  output logic [7:0] pre_data,
  output logic       pre_valid
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;
  logic       valid_r;
  logic       valid_nxt;
  logic       take_in;

  // new byte lands in the first empty cell of the chain
  assign take_in   = ctrl.load && !valid_r && left_valid;
  assign pre_data  = take_in ? din : (edit_en ? edit_data : data_r);
  assign pre_valid = valid_r || take_in;

  assign data_nxt  = ctrl.shift ? right_data  : pre_data;
  assign valid_nxt = ctrl.shift ? right_valid : pre_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q  = data_r;
  assign valid_q = valid_r;

endmodule

@@ rtl/core/mptp_scan.sv @@
// pattern compare at the window front, priority select and edit generation
// depends on mptp_pkg; purely combinational, one shallow compare per pattern byte
module mptp_scan
  import mptp_pkg::*;
(
  input  logic [SCAN_SPAN-1:0][7:0] win_data,
  input  logic [SCAN_SPAN-1:0]      win_valid,
  input  logic                      scan_en,
  input  logic [7:0]                digit,
  output scan_edit_t                edit
);

  logic hyp_eq;
  logic cores_eq;
  logic sib_eq;
  logic hex_eq;
  logic hyp_m;
  logic cores_m;
  logic sib_m;
  logic hex_m;

  always_comb begin
    hyp_eq   = 1'b1;
    cores_eq = 1'b1;
    sib_eq   = 1'b1;
    hex_eq   = 1'b1;
    for (int i = 0; i < HYP_LEN; i++) begin
      hyp_eq = hyp_eq && (win_data[i] == PAT_HYP[i]);
    end
    for (int i = 0; i < CORES_LEN; i++) begin
      cores_eq = cores_eq && (win_data[i] == PAT_CORES[i]);
    end
    for (int i = 0; i < SIB_LEN; i++) begin
      sib_eq = sib_eq && (win_data[i] == PAT_SIB[i]);
    end
    for (int i = 0; i < HEX_LEN; i++) begin
      hex_eq = hex_eq && (win_data[i] == PAT_HEX[i]);
    end
  end

  // valid bits form a prefix, so the last pattern byte being valid covers the whole pattern
  assign hyp_m   = hyp_eq   && win_valid[HYP_LEN-1];
  assign cores_m = cores_eq && win_valid[CORES_LEN-1];
  assign sib_m   = sib_eq   && win_valid[SIB_LEN-1];
  assign hex_m   = hex_eq   && win_valid[HEX_LEN-1];

  always_comb begin
    edit = '0;
    if (scan_en) begin
      if (hyp_m) begin
        for (int i = 0; i < HYP_LEN; i++) begin
          edit.wr_en[i]   = 1'b1;
          edit.wr_data[i] = CH_SPACE;
        end
        edit.hit = 1'b1;
      end else if (cores_m) begin
        if (win_valid[CORES_LEN] && is_digit(win_data[CORES_LEN])) begin
          edit.wr_en[CORES_LEN]   = 1'b1;
          edit.wr_data[CORES_LEN] = digit;
          edit.hit                = 1'b1;
        end
      end else if (sib_m) begin
        if (win_valid[SIB_LEN] && is_digit(win_data[SIB_LEN])) begin
          edit.wr_en[SIB_LEN]   = 1'b1;
          edit.wr_data[SIB_LEN] = digit;
          edit.hit              = 1'b1;
        end
      end else if (hex_m) begin
        for (int i = 0; i < HEX_LEN; i++) begin
          edit.wr_en[i]   = 1'b1;
          edit.wr_data[i] = NEW_HEX[i];
        end
        edit.hit = 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/multi_pattern_text_patcher_core.sv @@
// top level of the multi-pattern text patcher
// depends on mptp_pkg, mptp_cell (16-cell window chain) and mptp_scan (front compare)
//
// Usage:
//   in_*  : one text byte per transaction in in_tdata[7:0]; in_tlast marks the
//           final byte of a buffer.
//   out_* : patched bytes in original order; out_tdata[7:0] is the byte,
//           out_tdata[20:8] the replacement count (nonzero only with out_tlast).
//   cfg_* : APB write/read of the replacement digit at address 0 (reset '8').
// Latency: a byte leaves the window on the transaction that brings the byte
//   15 places behind it, appearing on out_* from the output register in the next cycle.
// Throughput: one byte per cycle while a buffer streams in and out_tready is
//   high. The final byte starts a flush that drains the window one byte per
//   cycle through the cell chain while out_tready is high.
//   in_tready is low during the flush.
// Stall: a low out_tready holds the output register; the window and in_tready
//   hold with it, nothing is dropped.
// Reset empties the window and clears the counters and output valid; the digit returns to '8'.
module multi_pattern_text_patcher_core
  import mptp_pkg::*;
#(
  parameter int MAX_LEN = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic              in_tlast,
  // output stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // [7:0] out_byte, [20:8] replace_count, [23:21] zero
  output logic              out_tlast,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam logic [PW-1:0] SCAN_LIMIT = PW'(MAX_LEN - 16);
  localparam logic [PW-1:0] POS_MAX    = PW'(MAX_LEN);

  logic                      flush_r;
  logic                      flush_nxt;
  logic [PW-1:0]             pos_r;
  logic [PW-1:0]             pos_nxt;
  logic [COUNT_W-1:0]        hits_r;
  logic [COUNT_W-1:0]        hits_nxt;
  logic [COUNT_W-1:0]        hits_after;
  logic [DIGIT_W-1:0]        digit_r;
  logic [DIGIT_W-1:0]        digit_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [7:0]                out_data_r;
  logic                      out_last_r;
  logic [COUNT_W-1:0]        out_count_r;

  logic                      out_free;
  logic                      in_fire;
  logic                      norm_emit;
  logic                      flush_emit;
  logic                      emit;
  logic                      emit_last;
  logic                      scan_en;
  logic                      hit_inc;
  logic                      cfg_wr;
  cell_ctrl_t                cell_ctrl;
  scan_edit_t                scan_edit;

  logic [WIN_DEPTH-1:0][7:0] cell_data;
  logic [WIN_DEPTH-1:0]      cell_valid;
  logic [WIN_DEPTH-1:0][7:0] cell_pre;
  logic [WIN_DEPTH-1:0]      cell_pre_valid;

  // ---------------- handshake and emit control ----------------
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !flush_r && out_free;
  assign in_fire   = in_tvalid && in_tready;

  // window already holds 15 bytes: this transaction fills it and the front leaves
  assign norm_emit  = in_fire && !in_tlast && cell_valid[WIN_DEPTH-2];
  assign flush_emit = flush_r && out_free;
  assign emit       = norm_emit || flush_emit;
  assign emit_last  = flush_emit && !cell_valid[1];
  assign scan_en    = emit && (pos_r < SCAN_LIMIT);

  assign cell_ctrl.load  = in_fire;
  assign cell_ctrl.shift = emit;

  // ---------------- window chain ----------------
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    logic       left_v;
    logic [7:0] right_d;
    logic       right_v;
    logic       ed_en;
    logic [7:0] ed_data;

    if (k == 0) begin : g_head
      assign left_v = 1'b1;
    end else begin : g_body
      assign left_v = cell_valid[k-1];
    end

    if (k == WIN_DEPTH - 1) begin : g_tail
      assign right_d = 8'h00;
      assign right_v = 1'b0;
    end else begin : g_link
      assign right_d = cell_pre[k+1];
      assign right_v = cell_pre_valid[k+1];
    end

    if (k < SCAN_SPAN) begin : g_edit
      assign ed_en   = scan_edit.wr_en[k];
      assign ed_data = scan_edit.wr_data[k];
    end else begin : g_noedit
      assign ed_en   = 1'b0;
      assign ed_data = 8'h00;
    end

    mptp_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .din        (in_tdata),
      .left_valid (left_v),
      .edit_en    (ed_en),
      .edit_data  (ed_data),
      .right_data (right_d),
      .right_valid(right_v),
      .data_q     (cell_data[k]),
      .valid_q    (cell_valid[k]),
      .pre_data   (cell_pre[k]),
      .pre_valid  (cell_pre_valid[k])
    );
  end

  mptp_scan u_scan (
    .win_data (cell_data[SCAN_SPAN-1:0]),
    .win_valid(cell_valid[SCAN_SPAN-1:0]),
    .scan_en  (scan_en),
    .digit    ({2'b00, digit_r}),
    .edit     (scan_edit)
  );

  // ---------------- counters and configuration ----------------
  assign hit_inc    = scan_edit.hit && (hits_r != COUNT_MAX);
  assign hits_after = hits_r + COUNT_W'(hit_inc);

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    flush_nxt = flush_r;
    if (emit_last) begin
      flush_nxt = 1'b0;
    end else if (in_fire && in_tlast) begin
      flush_nxt = 1'b1;
    end

    pos_nxt = pos_r;
    if (emit_last) begin
      pos_nxt = '0;
    end else if (emit && (pos_r != POS_MAX)) begin
      pos_nxt = pos_r + PW'(1);
    end

    hits_nxt = hits_r;
    if (emit_last) begin
      hits_nxt = '0;
    end else if (emit) begin
      hits_nxt = hits_after;
    end

    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    digit_nxt = digit_r;
    if (cfg_wr && (cfg_paddr[CFG_AW-1] == REG_IDX_DIGIT)) begin
      digit_nxt = cfg_pwdata[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r     <= 1'b0;
      pos_r       <= '0;
      hits_r      <= '0;
      digit_r     <= DIGIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      flush_r     <= flush_nxt;
      pos_r       <= pos_nxt;
      hits_r      <= hits_nxt;
      digit_r     <= digit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r  <= cell_pre[0];
      out_last_r  <= emit_last;
      out_count_r <= emit_last ? hits_after : '0;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_AW-1] == REG_IDX_DIGIT) begin
      cfg_prdata = {{(CFG_DW-DIGIT_W){1'b0}}, digit_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_data_r};
  assign out_tlast  = out_last_r;

  // ---------------- assertions ----------------
  // occupied cells always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("window cells not contiguous");

  // outside a flush the window never holds a full 16 bytes
  a_no_full_stream: assert property (@(posedge clk) disable iff (!rst_n)
    !flush_r |-> !cell_valid[WIN_DEPTH-1])
    else $error("window full while streaming");

  // a flush always has a byte at the front to drain
  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> cell_valid[0])
    else $error("flush with empty window");

  // the final byte of a buffer leaves the block empty and the counters cleared
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit_last |=> (!flush_r && (pos_r == '0) && (hits_r == '0) && (cell_valid == '0)))
    else $error("buffer end did not clear state");

endmodule
